@@ rtl/checked_int32_alu_macros.svh @@
// Assertion macros for the checked ALU checker.
// No dependencies.
`ifndef CHECKED_INT32_ALU_MACROS_SVH
`define CHECKED_INT32_ALU_MACROS_SVH
// assert that a condition implies a consequence in the same cycle
`define CIA_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");
// assert that a condition implies a consequence in the next cycle
`define CIA_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/cia_pkg.sv @@
// Types, codes and constants shared by the checked ALU.
// No dependencies.
package cia_pkg;
    localparam int W = 32;
    localparam int DIV_STEP = 4;
    localparam int DIV_STAGES = W / DIV_STEP;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2,
        OP_DIV = 3'd3, OP_REM = 3'd4, OP_NEG = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_ADD_OVF = 3'd1, ST_SUB_OVF = 3'd2,
        ST_MUL_OVF = 3'd3, ST_DIV_ZERO = 3'd4, ST_DIV_OVF = 3'd5
    } status_t;

    // side info carried along the divider pipeline
    typedef struct packed {
        logic [2:0]   kind;
        logic [W-1:0] a;
        logic [W-1:0] res;
        logic [2:0]   status;
        logic         is_div;
        logic         q_neg;
        logic         r_neg;
        logic         lt;
        logic         eq;
        logic         mul_en;
    } side_t;

    typedef struct packed {
        logic [W-1:0] result;
        logic [2:0]   status;
        logic         a_less_b;
        logic         a_equal_b;
    } res_t;
endpackage

@@ rtl/cia_if.sv @@
// Valid/ready channel interfaces for the checked ALU.
// Depends on cia_pkg.
interface cia_in_if;
    logic                    valid;
    logic                    ready;
    logic [2:0]              kind;
    logic signed [cia_pkg::W-1:0] operand_a;
    logic signed [cia_pkg::W-1:0] operand_b;
    modport source (output valid, kind, operand_a, operand_b, input ready);
    modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface cia_out_if;
    logic                    valid;
    logic                    ready;
    logic signed [cia_pkg::W-1:0] result;
    logic [2:0]              status;
    logic                    a_less_b;
    logic                    a_equal_b;
    modport source (output valid, result, status, a_less_b, a_equal_b, input ready);
    modport sink (input valid, result, status, a_less_b, a_equal_b, output ready);
endinterface

@@ rtl/cia_div_stage.sv @@
// One radix-16 restoring division stage: four quotient bits per stage.
// Depends on cia_pkg.
module cia_div_stage (
    input  logic [cia_pkg::W-1:0] rem_in,
    input  logic [cia_pkg::W-1:0] num_in,
    input  logic [cia_pkg::W-1:0] den,
    output logic [cia_pkg::W-1:0] rem_out,
    output logic [cia_pkg::W-1:0] num_out
);
    logic [cia_pkg::W:0]   r;
    logic [cia_pkg::W-1:0] n;
    always_comb
    begin
        r = {1'b0, rem_in};
        n = num_in;
        for (int i = 0; i < cia_pkg::DIV_STEP; i++)
        begin
            r = {r[cia_pkg::W-1:0], n[cia_pkg::W-1]};
            n = {n[cia_pkg::W-2:0], 1'b0};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                n[0] = 1'b1;
            end
        end
        rem_out = r[cia_pkg::W-1:0];
        num_out = n;
    end
endmodule

@@ rtl/checked_int32_alu.sv @@
// Checked 32-bit signed ALU: add, sub, mul, div, rem, negate with status.
// Depends on cia_pkg, cia_if, cia_div_stage.
//
//   channel | dir | payload
//   in      | in  | kind, operand_a, operand_b
//   out     | out | result, status, a_less_b, a_equal_b
//
// One item a cycle unless the output stalls; stage 0, divider, output reg.
// Reset clears all valid bits. A stall at the output freezes every stage;
// in.ready is low only while the last stage holds an untaken result.
module checked_int32_alu (
    input  logic clk,
    input  logic rst_n,
    cia_in_if.sink    in,
    cia_out_if.source out
);
    localparam int W = cia_pkg::W;
    localparam int NS = cia_pkg::DIV_STAGES;

    logic adv;
    assign adv = !out.valid || out.ready;
    assign in.ready = adv;

    // stage 0: decode, magnitudes, add/sub, compares, mul operands
    logic [NS+1:0]       v_reg;
    cia_pkg::side_t      s_reg [NS+2];
    logic [W-1:0]        rem_reg [NS+1];
    logic [W-1:0]        num_reg [NS+1];
    logic [W-1:0]        den_reg [NS+1];
    logic signed [2*W-1:0] prod_reg;
    cia_pkg::side_t      s0_next;
    logic [W-1:0]        ua, ub;
    logic signed [W:0]   sum, dif;
    logic signed [W-1:0] a, b;

    always_comb
    begin
        a = in.operand_a;
        b = in.operand_b;
        ua = a[W-1] ? W'(-a) : a;
        ub = b[W-1] ? W'(-b) : b;
        sum = {a[W-1], a} + {b[W-1], b};
        dif = {a[W-1], a} - {b[W-1], b};
        s0_next = '0;
        s0_next.kind = in.kind;
        s0_next.a = a;
        s0_next.res = a;
        s0_next.status = cia_pkg::ST_OK;
        s0_next.lt = a < b;
        s0_next.eq = a == b;
        s0_next.q_neg = a[W-1] ^ b[W-1];
        s0_next.r_neg = a[W-1];
        case (in.kind)
            cia_pkg::OP_ADD:
                if (sum[W] != sum[W-1]) s0_next.status = cia_pkg::ST_ADD_OVF;
                else s0_next.res = sum[W-1:0];
            cia_pkg::OP_SUB:
                if (dif[W] != dif[W-1]) s0_next.status = cia_pkg::ST_SUB_OVF;
                else s0_next.res = dif[W-1:0];
            cia_pkg::OP_MUL: s0_next.mul_en = 1'b1;
            cia_pkg::OP_DIV, cia_pkg::OP_REM:
            begin
                if (b == '0) s0_next.status = cia_pkg::ST_DIV_ZERO;
                else if (in.kind == cia_pkg::OP_DIV && a == {1'b1, {(W-1){1'b0}}}
                         && b == '1)
                    s0_next.status = cia_pkg::ST_DIV_OVF;
                else s0_next.is_div = 1'b1;
            end
            cia_pkg::OP_NEG: s0_next.res = W'(-a);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[NS:0], in.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[0] <= s0_next;
            rem_reg[0] <= '0;
            num_reg[0] <= ua;
            den_reg[0] <= ub;
            // product is registered here, then checked in the first divider stage
            prod_reg <= (2*W)'(in.operand_a) * (2*W)'(in.operand_b);
        end
    end

    // divider stages, multiply result folded in after the first
    for (genvar g = 0; g < NS; g++)
    begin : g_div
        logic [W-1:0]   r_o, n_o;
        cia_pkg::side_t sn;
        cia_div_stage u_st (.rem_in(rem_reg[g]), .num_in(num_reg[g]),
                            .den(den_reg[g]), .rem_out(r_o), .num_out(n_o));
        always_comb
        begin
            sn = s_reg[g];
            if (g == 0 && sn.mul_en)
            begin
                if (prod_reg[2*W-1:W-1] != '0 && prod_reg[2*W-1:W-1] != '1)
                    sn.status = cia_pkg::ST_MUL_OVF;
                else sn.res = prod_reg[W-1:0];
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_reg[g+1] <= sn;
                rem_reg[g+1] <= r_o;
                num_reg[g+1] <= n_o;
                den_reg[g+1] <= den_reg[g];
            end
        end
    end

    // sign fix and output register
    cia_pkg::side_t sl;
    cia_pkg::res_t  o_next, o_reg;
    always_comb
    begin
        sl = s_reg[NS];
        o_next.status = sl.status;
        o_next.a_less_b = sl.lt;
        o_next.a_equal_b = sl.eq;
        o_next.result = sl.res;
        if (sl.is_div)
        begin
            if (sl.kind == cia_pkg::OP_DIV)
                o_next.result = sl.q_neg ? W'(-num_reg[NS]) : num_reg[NS];
            else
                o_next.result = sl.r_neg ? W'(-rem_reg[NS]) : rem_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg[NS+1] <= sl;
            o_reg <= o_next;
        end
    end

    assign out.valid = v_reg[NS+1];
    assign out.result = o_reg.result;
    assign out.status = o_reg.status;
    assign out.a_less_b = o_reg.a_less_b;
    assign out.a_equal_b = o_reg.a_equal_b;
endmodule

@@ rtl/cia_checker.sv @@
// Port-level checker for the checked ALU, bound to the top level.
// Depends on cia_pkg, cia_if and checked_int32_alu_macros.svh.
`include "checked_int32_alu_macros.svh"
module cia_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] status,
    input logic a_less_b,
    input logic a_equal_b
);
    `CIA_ASSERT_IMP(flags_excl, out_valid, !(a_less_b && a_equal_b))
    `CIA_ASSERT_IMP(status_legal, out_valid, status <= 3'(cia_pkg::ST_DIV_OVF))
    `CIA_ASSERT_IMP(ready_when_free, !out_valid || out_ready, in_ready)
    `CIA_ASSERT_NEXT(hold_stall, out_valid && !out_ready, out_valid && $stable(status))
endmodule

bind checked_int32_alu cia_checker u_cia_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in.ready), .out_valid(out.valid),
    .out_ready(out.ready), .status(out.status), .a_less_b(out.a_less_b),
    .a_equal_b(out.a_equal_b)
);

@@ tb/testbench.sv @@
// Self-checking bench for the checked 32-bit signed ALU.
// Depends on cia_pkg, cia_if and checked_int32_alu; drives directed rows, then random items.
module testbench;
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cia_in_if  in_ch();
    cia_out_if out_ch();

    checked_int32_alu dut (.clk(clk), .rst_n(rst_n), .in(in_ch.sink), .out(out_ch.source));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct {
        logic [31:0] result;
        logic [2:0]  status;
        logic        lt;
        logic        eq;
    } alu_out_t;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
        bit          typed;
        logic [31:0] result;
        logic [2:0]  status;
    } row_t;

    localparam logic [31:0] MIN32 = 32'h8000_0000;
    localparam logic [31:0] MAX32 = 32'h7fff_ffff;
    localparam logic [31:0] NEG1  = 32'hffff_ffff;
    localparam logic [2:0]  KIND_SIX = 3'd6;
    localparam logic [2:0]  KIND_SEVEN = 3'd7;
    localparam longint      LO32 = -64'sd2147483648;
    localparam longint      HI32 = 64'sd2147483647;

    alu_out_t pending_results[$];
    int  errors = 0;
    int  send_idle = 0;
    int  recv_stall = 0;
    bit  sending_done = 1'b0;

    function automatic alu_out_t compute_alu(logic [2:0] kind, logic [31:0] a_raw,
                                             logic [31:0] b_raw);
        alu_out_t o;
        longint a;
        longint b;
        longint t;
        a = longint'($signed(a_raw));
        b = longint'($signed(b_raw));
        o.result = a_raw;
        o.status = cia_pkg::ST_OK;
        case (kind)
            cia_pkg::OP_ADD:
            begin
                t = a + b;
                if (t >= LO32 && t <= HI32) o.result = t[31:0];
                else o.status = cia_pkg::ST_ADD_OVF;
            end
            cia_pkg::OP_SUB:
            begin
                t = a - b;
                if (t >= LO32 && t <= HI32) o.result = t[31:0];
                else o.status = cia_pkg::ST_SUB_OVF;
            end
            cia_pkg::OP_MUL:
            begin
                t = a * b;
                if (t >= LO32 && t <= HI32) o.result = t[31:0];
                else o.status = cia_pkg::ST_MUL_OVF;
            end
            cia_pkg::OP_DIV:
            begin
                if (b == 0) o.status = cia_pkg::ST_DIV_ZERO;
                else if (a_raw == MIN32 && b == -1) o.status = cia_pkg::ST_DIV_OVF;
                else
                begin
                    t = a / b;
                    o.result = t[31:0];
                end
            end
            cia_pkg::OP_REM:
            begin
                if (b == 0) o.status = cia_pkg::ST_DIV_ZERO;
                else
                begin
                    t = a % b;
                    o.result = t[31:0];
                end
            end
            cia_pkg::OP_NEG:
            begin
                t = -a;
                o.result = t[31:0];
            end
            default: ;
        endcase
        o.lt = (a < b);
        o.eq = (a == b);
        return o;
    endfunction

    function automatic row_t mk(logic [2:0] k, logic [31:0] a, logic [31:0] b,
                                bit typed = 1'b0, logic [31:0] r = '0,
                                logic [2:0] s = cia_pkg::ST_OK);
        row_t x;
        x.kind = k; x.a = a; x.b = b; x.typed = typed; x.result = r; x.status = s;
        return x;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return MIN32;
            1: return MAX32;
            2: return NEG1;
            3: return 32'd0;
            4: return 32'($signed($urandom_range(0, 20)) - 10);
            5: return 32'($signed($urandom_range(0, 131070)) - 65535);
            6: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    // send one item; hold valid until the transfer
    task automatic send_item(logic [2:0] k, logic [31:0] a, logic [31:0] b);
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= k;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        pending_results.push_back(compute_alu(k, a, b));
        do @(posedge clk); while (!in_ch.ready);
    endtask

    row_t rows[$];

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.kind = cia_pkg::OP_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        rows = '{
            mk(cia_pkg::OP_ADD, 32'd0, 32'd0, 1'b1, 32'd0, cia_pkg::ST_OK),
            mk(cia_pkg::OP_ADD, MAX32, 32'd1, 1'b1, MAX32, cia_pkg::ST_ADD_OVF),
            mk(cia_pkg::OP_ADD, MIN32, NEG1, 1'b1, MIN32, cia_pkg::ST_ADD_OVF),
            mk(cia_pkg::OP_ADD, MAX32, MIN32, 1'b1, NEG1, cia_pkg::ST_OK),
            mk(cia_pkg::OP_SUB, MIN32, 32'd1, 1'b1, MIN32, cia_pkg::ST_SUB_OVF),
            mk(cia_pkg::OP_SUB, 32'd0, MIN32, 1'b1, 32'd0, cia_pkg::ST_SUB_OVF),
            mk(cia_pkg::OP_SUB, NEG1, MAX32, 1'b1, MIN32, cia_pkg::ST_OK),
            mk(cia_pkg::OP_MUL, MIN32, 32'd1, 1'b1, MIN32, cia_pkg::ST_OK),
            mk(cia_pkg::OP_MUL, MIN32, NEG1, 1'b1, MIN32, cia_pkg::ST_MUL_OVF),
            mk(cia_pkg::OP_MUL, 32'h0001_0000, 32'hffff_8000, 1'b1, MIN32,
               cia_pkg::ST_OK),
            mk(cia_pkg::OP_MUL, 32'h0001_0000, 32'h0000_8000, 1'b1, 32'h0001_0000,
               cia_pkg::ST_MUL_OVF),
            mk(cia_pkg::OP_MUL, MAX32, NEG1),
            mk(cia_pkg::OP_DIV, 32'd7, 32'd0, 1'b1, 32'd7, cia_pkg::ST_DIV_ZERO),
            mk(cia_pkg::OP_DIV, MIN32, NEG1, 1'b1, MIN32, cia_pkg::ST_DIV_OVF),
            mk(cia_pkg::OP_DIV, 32'hffff_fff9, 32'd2),
            mk(cia_pkg::OP_DIV, MAX32, MIN32),
            mk(cia_pkg::OP_REM, MIN32, NEG1, 1'b1, 32'd0, cia_pkg::ST_OK),
            mk(cia_pkg::OP_REM, 32'd5, 32'd0, 1'b1, 32'd5, cia_pkg::ST_DIV_ZERO),
            mk(cia_pkg::OP_REM, 32'hffff_fff9, 32'd2),
            mk(cia_pkg::OP_NEG, MIN32, 32'd3, 1'b1, MIN32, cia_pkg::ST_OK),
            mk(cia_pkg::OP_NEG, MAX32, MAX32),
            mk(KIND_SIX, 32'd12, 32'd12, 1'b1, 32'd12, cia_pkg::ST_OK),
            mk(KIND_SEVEN, MIN32, MAX32, 1'b1, MIN32, cia_pkg::ST_OK)
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            send_item(rows[i].kind, rows[i].a, rows[i].b);
            if (rows[i].typed)
            begin
                alu_out_t e;
                e = pending_results[$];
                if (e.result !== rows[i].result || e.status !== rows[i].status)
                begin
                    $display("%0t: table row %0d: expected %h/%0d, predicted %h/%0d",
                             $time, i, rows[i].result, rows[i].status, e.result, e.status);
                    errors++;
                end
            end
        end
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 81 : 22) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 81 : 22) : 0;
            for (int n = 0; n < 175; n++)
            begin
                logic [2:0] k;
                logic [31:0] a;
                logic [31:0] b;
                k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
                a = rand_operand();
                b = ($urandom_range(0, 7) == 0) ? a : rand_operand();
                send_item(k, a, b);
            end
        end
        in_ch.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver: random stalls, compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                alu_out_t e;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_ch.result);
                    errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (out_ch.result !== e.result)
                    begin
                        $display("%0t: result expected %h actual %h",
                                 $time, e.result, out_ch.result);
                        errors++;
                    end
                    if (out_ch.status !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, out_ch.status);
                        errors++;
                    end
                    if (out_ch.a_less_b !== e.lt)
                    begin
                        $display("%0t: a_less_b expected %b actual %b",
                                 $time, e.lt, out_ch.a_less_b);
                        errors++;
                    end
                    if (out_ch.a_equal_b !== e.eq)
                    begin
                        $display("%0t: a_equal_b expected %b actual %b",
                                 $time, e.eq, out_ch.a_equal_b);
                        errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    initial
    begin
        wait (sending_done);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (cia_pkg::DIV_STAGES + 3 + 20) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/cia_pkg.sv
rtl/cia_if.sv
rtl/cia_div_stage.sv
rtl/checked_int32_alu.sv
rtl/cia_checker.sv
tb/testbench.sv
